### rtl/text_terminal_writer_macros.svh
// ----------------------------------------------------------------------------
// Text terminal writer assertion macros
// Shared concurrent assertion forms; the asserting scope provides clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef TEXT_TERMINAL_WRITER_MACROS_SVH
`define TEXT_TERMINAL_WRITER_MACROS_SVH

// Check that cons holds in every cycle in which ante holds.
`define TTW_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cond holds in every cycle out of reset.
`define TTW_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`endif

### rtl/ttw_pkg.sv
// ----------------------------------------------------------------------------
// Text terminal writer package
// Word types, operation codes, state encoding and fixed constants.
// ----------------------------------------------------------------------------
package ttw_pkg;

    // Request codes
    localparam logic [1:0] REQ_PUT   = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // Bytes with special meaning
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_BLANK = 8'h20;

    localparam logic [7:0] ATTR_RESET = 8'h07;

    // Linear cell address wide enough for the largest screen, and one bit more
    // for range compares against the cell count.
    localparam int CADDR_W   = 12;
    localparam int IDX_CMP_W = 13;

    // Command queue
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] char_byte;
        logic [10:0] cell_index;
        logic       write_last;
    } ttw_req_t;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
        logic [6:0] cursor_column;
        logic [4:0] cursor_line;
        logic       cursor_commit;
    } ttw_rsp_t;

    typedef enum logic [2:0] {
        OP_WRITE,
        OP_NEWLINE,
        OP_CR,
        OP_BS,
        OP_READ,
        OP_CLEAR,
        OP_NOP
    } ttw_op_t;

    typedef struct packed {
        ttw_op_t              op;
        logic [7:0]           data;
        logic [CADDR_W-1:0]   addr;
        logic                 in_range;
        logic                 commit;
    } ttw_item_t;

    typedef struct packed {
        logic valid;
        logic full;
    } ttw_qstat_t;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_IDLE,
        ST_READ,
        ST_SCROLL_RD,
        ST_SCROLL_WR
    } ttw_state_t;

endpackage

### rtl/ttw_front.sv
// ----------------------------------------------------------------------------
// Text terminal writer front end
// Accepts request words and classifies them into queue operations.
// ----------------------------------------------------------------------------
module ttw_front
    import ttw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  logic       start,
    input  ttw_req_t   request,
    input  ttw_qstat_t q_stat,
    input  logic       init_busy,
    output logic       busy,
    output logic       push,
    output ttw_item_t  item
);

    localparam int CELLS = COLUMNS * ROWS;

    assign busy = q_stat.full || init_busy;
    assign push = start && !busy;

    always_comb
    begin
        item          = '0;
        item.op       = OP_NOP;
        item.data     = request.char_byte;
        item.addr     = CADDR_W'(request.cell_index);
        item.in_range = IDX_CMP_W'(request.cell_index) < IDX_CMP_W'(CELLS);
        item.commit   = 1'b0;
        case (request.req_type)
            REQ_PUT:
            begin
                item.commit = request.write_last;
                case (request.char_byte)
                    CH_NL:   item.op = OP_NEWLINE;
                    CH_CR:   item.op = OP_CR;
                    CH_BS:   item.op = OP_BS;
                    CH_TAB:
                    begin
                        // Tab writes a blank and advances like any printable byte
                        item.op   = OP_WRITE;
                        item.data = CH_BLANK;
                    end
                    default: item.op = OP_WRITE;
                endcase
            end
            REQ_READ:  item.op = OP_READ;
            REQ_CLEAR:
            begin
                item.op     = OP_CLEAR;
                item.commit = 1'b1;
            end
            default:   item.op = OP_NOP;
        endcase
    end

endmodule

### rtl/ttw_queue.sv
// ----------------------------------------------------------------------------
// Text terminal writer command queue
// Short FIFO of classified operations between front and back end.
// ----------------------------------------------------------------------------
module ttw_queue
    import ttw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  ttw_item_t  push_item,
    input  logic       pop,
    output ttw_item_t  head,
    output ttw_qstat_t q_stat
);

    ttw_item_t           q_mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg,  count_next;
    logic                do_push, do_pop;

    assign q_stat.valid = (count_reg != '0);
    assign q_stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign head         = q_mem_reg[rd_ptr_reg];

    assign do_push = push && !q_stat.full;
    assign do_pop  = pop && q_stat.valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### rtl/ttw_back.sv
// ----------------------------------------------------------------------------
// Text terminal writer back end
// Executes queued operations on the cursor and the screen memories.
// ----------------------------------------------------------------------------
module ttw_back
    import ttw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  ttw_qstat_t q_stat,
    input  ttw_item_t  head,
    input  logic [7:0] text_attribute,
    output logic       pop,
    output logic       init_busy,
    output logic       done,
    output ttw_rsp_t   result
);

    localparam int CELLS        = COLUMNS * ROWS;
    localparam int AW           = $clog2(CELLS);
    localparam int SCROLL_CELLS = (ROWS - 1) * COLUMNS;

    localparam logic [6:0]    LAST_COL   = 7'(COLUMNS - 1);
    localparam logic [4:0]    LAST_ROW   = 5'(ROWS - 1);
    localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
    localparam logic [AW-1:0] SCROLL_END = AW'(SCROLL_CELLS);
    localparam logic [AW-1:0] ROW_STEP   = AW'(COLUMNS);

    ttw_state_t    state_reg, state_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [6:0]    col_reg, col_next;
    logic [4:0]    row_reg, row_next;
    logic [7:0]    fill_attr_reg, fill_attr_next;
    logic          fill_report_reg, fill_report_next;
    logic          commit_reg, commit_next;
    logic          done_reg, done_next;
    ttw_rsp_t      rsp_reg, rsp_next;
    logic          read_ok_reg, read_ok_next;

    logic [7:0]    chars_mem [CELLS];
    logic [7:0]    attrs_mem [CELLS];
    logic [7:0]    rd_ch_reg, rd_at_reg;

    logic          ch_we, at_we;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    wch, wat;

    logic [6:0]         bs_col;
    logic [4:0]         bs_row;
    logic [CADDR_W-1:0] cur_lin, bs_lin;
    logic               in_upper;

    assign done      = done_reg;
    assign result    = rsp_reg;
    assign init_busy = (state_reg == ST_FILL) && !fill_report_reg;

    // Backspace target: step left, wrap to the previous row, stick at origin
    always_comb
    begin
        bs_col = col_reg;
        bs_row = row_reg;
        if (col_reg == '0)
        begin
            if (row_reg != '0)
            begin
                bs_row = row_reg - 1'b1;
                bs_col = LAST_COL;
            end
        end
        else
        begin
            bs_col = col_reg - 1'b1;
        end
    end

    assign cur_lin  = CADDR_W'(row_reg) * CADDR_W'(COLUMNS) + CADDR_W'(col_reg);
    assign bs_lin   = CADDR_W'(bs_row) * CADDR_W'(COLUMNS) + CADDR_W'(bs_col);
    assign in_upper = idx_reg < SCROLL_END;

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        col_next         = col_reg;
        row_next         = row_reg;
        fill_attr_next   = fill_attr_reg;
        fill_report_next = fill_report_reg;
        commit_next      = commit_reg;
        read_ok_next     = read_ok_reg;
        done_next        = 1'b0;
        rsp_next         = rsp_reg;
        pop              = 1'b0;
        ch_we            = 1'b0;
        at_we            = 1'b0;
        waddr            = idx_reg;
        raddr            = idx_reg;
        wch              = CH_BLANK;
        wat              = fill_attr_reg;

        case (state_reg)
            ST_FILL:
            begin
                ch_we = 1'b1;
                at_we = 1'b1;
                if (idx_reg == LAST_CELL)
                begin
                    col_next   = '0;
                    row_next   = '0;
                    state_next = ST_IDLE;
                    if (fill_report_reg)
                    begin
                        done_next = 1'b1;
                        rsp_next  = '{8'd0, 8'd0, 7'd0, 5'd0, commit_reg};
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (q_stat.valid)
                begin
                    pop         = 1'b1;
                    commit_next = head.commit;
                    raddr       = head.addr[AW-1:0];
                    done_next   = 1'b1;
                    case (head.op)
                        OP_WRITE:
                        begin
                            ch_we = 1'b1;
                            at_we = 1'b1;
                            waddr = cur_lin[AW-1:0];
                            wch   = head.data;
                            wat   = text_attribute;
                            if (col_reg == LAST_COL)
                            begin
                                col_next = '0;
                                if (row_reg == LAST_ROW)
                                begin
                                    done_next  = 1'b0;
                                    idx_next   = '0;
                                    state_next = ST_SCROLL_RD;
                                end
                                else
                                begin
                                    row_next = row_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                col_next = col_reg + 1'b1;
                            end
                        end
                        OP_NEWLINE:
                        begin
                            col_next = '0;
                            if (row_reg == LAST_ROW)
                            begin
                                done_next  = 1'b0;
                                idx_next   = '0;
                                state_next = ST_SCROLL_RD;
                            end
                            else
                            begin
                                row_next = row_reg + 1'b1;
                            end
                        end
                        OP_CR:
                        begin
                            col_next = '0;
                        end
                        OP_BS:
                        begin
                            ch_we    = 1'b1;
                            at_we    = 1'b1;
                            waddr    = bs_lin[AW-1:0];
                            wch      = CH_BLANK;
                            wat      = text_attribute;
                            col_next = bs_col;
                            row_next = bs_row;
                        end
                        OP_READ:
                        begin
                            done_next    = 1'b0;
                            read_ok_next = head.in_range;
                            state_next   = ST_READ;
                        end
                        OP_CLEAR:
                        begin
                            done_next        = 1'b0;
                            idx_next         = '0;
                            fill_attr_next   = text_attribute;
                            fill_report_next = 1'b1;
                            state_next       = ST_FILL;
                        end
                        default:
                        begin
                            // Unused request: report the cursor, touch nothing
                        end
                    endcase
                    rsp_next = '{8'd0, 8'd0, col_next, row_next, head.commit};
                end
            end

            ST_READ:
            begin
                done_next  = 1'b1;
                rsp_next   = '{read_ok_reg ? rd_ch_reg : 8'd0,
                               read_ok_reg ? rd_at_reg : 8'd0,
                               col_reg, row_reg, 1'b0};
                state_next = ST_IDLE;
            end

            ST_SCROLL_RD:
            begin
                raddr      = idx_reg + ROW_STEP;
                state_next = ST_SCROLL_WR;
            end

            ST_SCROLL_WR:
            begin
                // Characters move up a row; attributes stay in place
                ch_we = 1'b1;
                wch   = in_upper ? rd_ch_reg : CH_BLANK;
                if (idx_reg == LAST_CELL)
                begin
                    done_next  = 1'b1;
                    rsp_next   = '{8'd0, 8'd0, col_reg, row_reg, commit_reg};
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SCROLL_RD;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_FILL;
            idx_reg         <= '0;
            col_reg         <= '0;
            row_reg         <= '0;
            fill_attr_reg   <= ATTR_RESET;
            fill_report_reg <= 1'b0;
            commit_reg      <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
            fill_attr_reg   <= fill_attr_next;
            fill_report_reg <= fill_report_next;
            commit_reg      <= commit_next;
            done_reg        <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg     <= rsp_next;
        read_ok_reg <= read_ok_next;
    end

    always_ff @(posedge clk)
    begin
        if (ch_we)
        begin
            chars_mem[waddr] <= wch;
        end
        rd_ch_reg <= chars_mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (at_we)
        begin
            attrs_mem[waddr] <= wat;
        end
        rd_at_reg <= attrs_mem[raddr];
    end

endmodule

### rtl/text_terminal_writer.sv
// ----------------------------------------------------------------------------
// Text terminal writer
// Character-cell terminal engine: cursor, screen memories and command queue.
// ----------------------------------------------------------------------------
// A request word is taken on any clock edge with start high and busy low and
// lands in a two-entry command queue; busy rises only while that queue is full
// or while the power-up clearing pass runs. Every word gives exactly one
// result word, shown on result for a single cycle with done high; the receiver
// has no way to stall it, so sample it on that cycle. After the back end pulls
// a word from the queue, printable bytes, tab, carriage return, backspace and
// newline report on the next cycle; a cell read reports from the read state
// (the screen memories have a registered read port). A byte that pushes the
// cursor past the bottom row scrolls the screen, with one memory read and one
// memory write per cell over all COLUMNS*ROWS cells, and reports at its end.
// A clear request walks the memories once, one cell per cycle. After reset the
// same walk loads blanks with attribute 7; busy stays high throughout it. Write
// the attribute register only while nothing is outstanding.
// ----------------------------------------------------------------------------
module text_terminal_writer
    import ttw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  ttw_req_t   request,
    output logic       done,
    output ttw_rsp_t   result,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata
);

    logic [7:0] text_attribute_reg, text_attribute_next;

    ttw_qstat_t q_stat;
    ttw_item_t  push_item;
    ttw_item_t  head;
    logic       push;
    logic       pop;
    logic       init_busy;

    // Attribute register: take the new byte on a write, hold otherwise
    assign text_attribute_next = cfg_we ? cfg_wdata : text_attribute_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_attribute_reg <= ATTR_RESET;
        end
        else
        begin
            text_attribute_reg <= text_attribute_next;
        end
    end

    // Decode request words into operations
    ttw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .start     (start),
        .request   (request),
        .q_stat    (q_stat),
        .init_busy (init_busy),
        .busy      (busy),
        .push      (push),
        .item      (push_item)
    );

    // Decouple acceptance from execution
    ttw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    // Execute operations against the cursor and the screen
    ttw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_stat         (q_stat),
        .head           (head),
        .text_attribute (text_attribute_reg),
        .pop            (pop),
        .init_busy      (init_busy),
        .done           (done),
        .result         (result)
    );

endmodule

### rtl/ttw_checker.sv
// ----------------------------------------------------------------------------
// Text terminal writer port checker
// Watches the top-level ports; flags impossible results and unknown requests.
// ----------------------------------------------------------------------------
`include "text_terminal_writer_macros.svh"

module ttw_checker
    import ttw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     busy,
    input  ttw_req_t request,
    input  logic     done,
    input  ttw_rsp_t result
);

    logic [2:0] pend_reg, pend_next;
    logic       accept;
    logic       cursor_ok;
    logic       cell_shown;

    assign accept    = start && !busy;
    assign pend_next = pend_reg + 3'(accept) - 3'(done);

    assign cursor_ok  = (8'(result.cursor_column) < 8'(COLUMNS)) &&
                        (6'(result.cursor_line) < 6'(ROWS));
    assign cell_shown = done && ((result.cell_char != 8'd0) || (result.cell_attr != 8'd0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    `TTW_ASSERT_IMPLIES(a_result_has_word, done, pend_reg != 3'd0, "result without a pending word")
    `TTW_ASSERT_ALWAYS(a_pend_bound, pend_reg <= 3'(QDEPTH + 1), "too many words outstanding")
    `TTW_ASSERT_IMPLIES(a_cursor_range, done, cursor_ok, "cursor off screen")
    `TTW_ASSERT_IMPLIES(a_read_no_commit, cell_shown, !result.cursor_commit, "commit on a read")
    `TTW_ASSERT_IMPLIES(a_request_known, accept, !$isunknown(request), "unknown request word")

endmodule

bind text_terminal_writer ttw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_ttw_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
);

### test/testbench.sv
// ----------------------------------------------------------------------------
// Text terminal writer testbench
// Drives put, read, clear and unused request words into the terminal engine
// and keeps a shadow screen and cursor that forecast every result word. The
// attribute register is changed between phases while the engine is idle, and
// each result is compared field by field with the oldest forecast.
// ----------------------------------------------------------------------------
module testbench;
    import ttw_pkg::*;

    localparam int COLS        = 80;
    localparam int LINES       = 25;
    localparam int CELLS       = COLS * LINES;
    localparam int QUIET_LIMIT = 40000;
    localparam int SHOW_LIMIT  = 10;

    // The package names no code for the fourth request type.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       start;
    logic       busy;
    ttw_req_t   request;
    logic       done;
    ttw_rsp_t   result;
    logic       cfg_we;
    logic [7:0] cfg_wdata;

    // Shadow of the engine: screen memories, cursor and attribute register.
    logic [7:0] shadow_chars [0:CELLS-1];
    logic [7:0] shadow_attrs [0:CELLS-1];
    logic [6:0] shadow_col;
    logic [4:0] shadow_row;
    logic [7:0] shadow_attr;

    ttw_rsp_t pending_reports [$];
    int       fault_count = 0;
    int       quiet_cycles = 0;
    bit       steady_run = 1'b0;

    text_terminal_writer #(
        .COLUMNS (COLS),
        .ROWS    (LINES)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Fill every cell with a space under the current attribute and home the cursor.
    function void blank_screen();
        for (int i = 0; i < CELLS; i++)
        begin
            shadow_chars[i] = CH_BLANK;
            shadow_attrs[i] = shadow_attr;
        end
        shadow_col = '0;
        shadow_row = '0;
    endfunction

    // Advance the shadow by one accepted word and return the result it must give.
    function ttw_rsp_t terminal_step(ttw_req_t w);
        ttw_rsp_t   r;
        logic [7:0] c;
        int         at;
        r = '0;
        case (w.req_type)
            REQ_PUT:
            begin
                c = w.char_byte;
                // Tab behaves as a plain space and the write goes on.
                if (c == CH_TAB)
                    c = CH_BLANK;
                if (c == CH_NL)
                begin
                    shadow_row = shadow_row + 1'b1;
                    shadow_col = '0;
                end
                else if (c == CH_CR)
                    shadow_col = '0;
                else if (c == CH_BS)
                begin
                    // Step back; wrap to the end of the row above, hold at the origin.
                    if (shadow_col == 0)
                    begin
                        if (shadow_row != 0)
                        begin
                            shadow_row = shadow_row - 1'b1;
                            shadow_col = 7'(COLS - 1);
                        end
                    end
                    else
                        shadow_col = shadow_col - 1'b1;
                    at = shadow_row * COLS + shadow_col;
                    shadow_chars[at] = CH_BLANK;
                    shadow_attrs[at] = shadow_attr;
                end
                else
                begin
                    at = shadow_row * COLS + shadow_col;
                    shadow_chars[at] = c;
                    shadow_attrs[at] = shadow_attr;
                    shadow_col = shadow_col + 1'b1;
                end
                if (shadow_col >= COLS)
                begin
                    shadow_col = '0;
                    shadow_row = shadow_row + 1'b1;
                end
                // Past the bottom: move characters up one row, keep attributes,
                // blank the last row.
                if (shadow_row >= LINES)
                begin
                    shadow_row = 5'(LINES - 1);
                    for (int i = 0; i < (LINES - 1) * COLS; i++)
                        shadow_chars[i] = shadow_chars[i + COLS];
                    for (int i = (LINES - 1) * COLS; i < CELLS; i++)
                        shadow_chars[i] = CH_BLANK;
                end
                r.cursor_commit = w.write_last;
            end
            REQ_READ:
            begin
                if (w.cell_index < CELLS)
                begin
                    r.cell_char = shadow_chars[w.cell_index];
                    r.cell_attr = shadow_attrs[w.cell_index];
                end
            end
            REQ_CLEAR:
            begin
                blank_screen();
                r.cursor_commit = 1'b1;
            end
            default:
                ;
        endcase
        r.cursor_column = shadow_col;
        r.cursor_line   = shadow_row;
        return r;
    endfunction

    // Check each result word against the oldest forecast, then forecast the
    // word accepted at this edge. Track register writes at the same edge.
    always @(posedge clk)
    begin
        ttw_rsp_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_reports.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= SHOW_LIMIT)
                        $display("unexpected result word %h", result);
                end
                else
                begin
                    want = pending_reports.pop_front();
                    if (result.cell_char !== want.cell_char ||
                        result.cell_attr !== want.cell_attr ||
                        result.cursor_column !== want.cursor_column ||
                        result.cursor_line !== want.cursor_line ||
                        result.cursor_commit !== want.cursor_commit)
                    begin
                        fault_count++;
                        if (fault_count <= SHOW_LIMIT)
                        begin
                            $write("result word: char %h/%h attr %h/%h col %0d/%0d",
                                   want.cell_char, result.cell_char,
                                   want.cell_attr, result.cell_attr,
                                   want.cursor_column, result.cursor_column);
                            $display(" line %0d/%0d commit %b/%b (expected/actual)",
                                     want.cursor_line, result.cursor_line,
                                     want.cursor_commit, result.cursor_commit);
                        end
                    end
                end
            end
            if (cfg_we)
                shadow_attr = cfg_wdata;
            if (start && !busy)
                pending_reports.push_back(terminal_step(request));
        end
    end

    // Drop the run when neither side moves a word for too long; a scroll of
    // the full screen is the longest legal silence.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("text_terminal_writer: mismatch");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Present one word and hold it until the engine takes it. Called and
    // returning on a falling edge; a gap of zero keeps start high throughout.
    task automatic issue_word(input ttw_req_t w);
        int gap;
        if ($urandom_range(0, 39) == 0)
            steady_run = !steady_run;
        gap = steady_run ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start   <= 1'b1;
        request <= w;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    task automatic put_char(input logic [7:0] c, input logic last);
        ttw_req_t w;
        w.req_type   = REQ_PUT;
        w.char_byte  = c;
        w.cell_index = 11'($urandom_range(0, 2047));
        w.write_last = last;
        issue_word(w);
    endtask

    task automatic read_cell(input int idx);
        ttw_req_t w;
        w.req_type   = REQ_READ;
        w.char_byte  = 8'($urandom_range(0, 255));
        w.cell_index = 11'(idx);
        w.write_last = 1'($urandom_range(0, 1));
        issue_word(w);
    endtask

    task automatic other_word(input logic [1:0] kind);
        ttw_req_t w;
        w.req_type   = kind;
        w.char_byte  = 8'($urandom_range(0, 255));
        w.cell_index = 11'($urandom_range(0, 2047));
        w.write_last = 1'($urandom_range(0, 1));
        issue_word(w);
    endtask

    // Drop start, wait for every forecast to be met, then let the engine settle.
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_reports.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_attribute(input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // Screen right after reset: spaces with attribute 7, reads past the end give zero.
    task automatic test_power_up_state();
        read_cell(0);
        read_cell(1024);
        read_cell(CELLS - 1);
        read_cell(CELLS);
        read_cell(2047);
    endtask

    // Every request type and each control byte, including the backspace
    // corner cases, tab and a column wrap from the last column.
    task automatic test_controls();
        wait_idle();
        set_attribute(8'hFF);
        put_char("H", 1'b0);
        put_char(8'h00, 1'b0);
        put_char(8'hFF, 1'b0);
        put_char(CH_TAB, 1'b0);
        put_char(CH_BS, 1'b1);
        read_cell(3);
        read_cell(0);
        put_char(CH_CR, 1'b0);
        put_char(CH_NL, 1'b1);
        // Backspace from column 0 lands on the last column of the row above.
        put_char(CH_BS, 1'b0);
        put_char("x", 1'b0);
        read_cell(COLS - 1);
        put_char(CH_BS, 1'b1);
        other_word(REQ_CLEAR);
        // Backspace at the origin holds the cursor and still blanks the cell.
        put_char(CH_BS, 1'b1);
        read_cell(0);
        other_word(REQ_UNUSED);
    endtask

    // Mostly typed lines with random text, newlines and backspaces, mixed with
    // reads aimed near the cursor and a share of noise words.
    task automatic test_random_traffic(input logic [7:0] attr_value, input int quota);
        int         issued;
        int         pick;
        int         len;
        int         ending;
        int         idx;
        logic [7:0] c;
        wait_idle();
        set_attribute(attr_value);
        issued = 0;
        while (issued < quota)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                // A few long lines, 70 to 100 bytes, often force column wrap.
                len = (pick < 4) ? $urandom_range(70, 100) : $urandom_range(1, 12);
                for (int k = 0; k < len; k++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        c = 8'($urandom_range(0, 255));
                    else
                        c = 8'($urandom_range(32, 126));
                    put_char(c, k == len - 1);
                end
                issued += len;
                ending = $urandom_range(0, 9);
                if (ending < 5)
                begin
                    put_char(CH_NL, 1'b1);
                    issued++;
                end
                else if (ending < 7)
                begin
                    put_char(CH_CR, 1'b0);
                    put_char(CH_NL, 1'b1);
                    issued += 2;
                end
            end
            else if (pick < 75)
            begin
                len = $urandom_range(1, 4);
                for (int k = 0; k < len; k++)
                begin
                    case ($urandom_range(0, 2))
                        0: idx = shadow_row * COLS + $urandom_range(0, COLS - 1);
                        1: idx = $urandom_range(0, CELLS - 1);
                        default: idx = $urandom_range(0, 2047);
                    endcase
                    read_cell(idx);
                end
                issued += len;
            end
            else if (pick < 90)
            begin
                len = $urandom_range(1, 5);
                for (int k = 0; k < len; k++)
                begin
                    case ($urandom_range(0, 4))
                        0: c = CH_TAB;
                        1: c = CH_CR;
                        2: c = CH_NL;
                        default: c = CH_BS;
                    endcase
                    put_char(c, 1'($urandom_range(0, 1)));
                end
                issued += len;
            end
            else if (pick < 92)
            begin
                other_word(REQ_CLEAR);
                issued++;
            end
            else if (pick < 94)
            begin
                other_word(REQ_UNUSED);
                issued++;
            end
            else
            begin
                other_word(2'($urandom_range(0, 3)));
                issued++;
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        request   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        shadow_attr = ATTR_RESET;
        blank_screen();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The power-up clearing pass holds busy; the handshake waits it out.
        test_power_up_state();
        test_controls();
        test_random_traffic(8'h00, 125);
        test_random_traffic(8'hFF, 125);
        test_random_traffic(8'($urandom_range(0, 255)), 125);
        test_random_traffic(ATTR_RESET, 125);
        test_random_traffic(8'($urandom_range(0, 255)), 125);

        wait_idle();
        repeat (20) @(negedge clk);
        fault_count += pending_reports.size();
        if (fault_count == 0)
            $display("text_terminal_writer: match");
        else
            $display("text_terminal_writer: mismatch");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/ttw_pkg.sv
rtl/ttw_front.sv
rtl/ttw_queue.sv
rtl/ttw_back.sv
rtl/text_terminal_writer.sv
rtl/ttw_checker.sv
test/testbench.sv
